### rtl/bpdd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpdd_pkg: shared types and constants of the border pixel density detector
// Register map, field widths, luma weights and the brightness test.
// ----------------------------------------------------------------------------
package bpdd_pkg;

   // Field widths
   localparam int PIX_W      = 8;
   localparam int DIM_W      = 13;
   localparam int THR_W      = 17;
   localparam int COUNT_W    = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register reset values
   localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;
   localparam logic [THR_W-1:0] THRESHOLD_RST    = 17'd49152;

   // Luma weights in Q14, with the rounding half
   localparam int LUMA_SHIFT = 14;
   localparam int LUMA_SUM_W = 22;
   localparam logic [LUMA_SUM_W-1:0] W_BLUE   = 22'd1868;
   localparam logic [LUMA_SUM_W-1:0] W_GREEN  = 22'd9617;
   localparam logic [LUMA_SUM_W-1:0] W_RED    = 22'd4899;
   localparam logic [LUMA_SUM_W-1:0] Q14_HALF = 22'd8192;
   localparam logic [PIX_W-1:0]      GRAY_LIMIT = 8'd70;

   // Register indexes (word address)
   typedef enum logic [1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_THRESHOLD    = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   // Raw register contents
   typedef struct packed {
      logic [DIM_W-1:0] frame_width;
      logic [DIM_W-1:0] frame_height;
      logic [THR_W-1:0] ratio_threshold;
   } csr_regs_type;

   // Gray level above the limit
   function automatic logic luma_bright(input logic [PIX_W-1:0] b,
                                        input logic [PIX_W-1:0] g,
                                        input logic [PIX_W-1:0] r);
      logic [LUMA_SUM_W-1:0] sum;
      logic [PIX_W-1:0]      gray;
      sum  = W_BLUE * LUMA_SUM_W'(b) + W_GREEN * LUMA_SUM_W'(g)
           + W_RED * LUMA_SUM_W'(r) + Q14_HALF;
      gray = sum[LUMA_SHIFT +: PIX_W];
      return gray > GRAY_LIMIT;
   endfunction

endpackage
`default_nettype wire

### rtl/bpdd_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpdd_csr: configuration registers
// APB-style write and read of frame width, frame height and ratio threshold.
// ----------------------------------------------------------------------------
module bpdd_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [bpdd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [bpdd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [bpdd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready,
   output bpdd_pkg::csr_regs_type                 regs
);
   import bpdd_pkg::*;

   csr_regs_type  regs_ff;
   reg_index_type index;
   logic          write_en;

   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign regs       = regs_ff;

   // Write on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.frame_width     <= FRAME_WIDTH_RST;
         regs_ff.frame_height    <= FRAME_HEIGHT_RST;
         regs_ff.ratio_threshold <= THRESHOLD_RST;
      end else if (write_en) begin
         case (index)
            REG_FRAME_WIDTH:  regs_ff.frame_width     <= csr_pwdata[DIM_W-1:0];
            REG_FRAME_HEIGHT: regs_ff.frame_height    <= csr_pwdata[DIM_W-1:0];
            REG_THRESHOLD:    regs_ff.ratio_threshold <= csr_pwdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (index)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_W'(regs_ff.frame_width);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_W'(regs_ff.frame_height);
         REG_THRESHOLD:    csr_prdata = CSR_DATA_W'(regs_ff.ratio_threshold);
         default:          csr_prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

### rtl/border_pixel_density_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// border_pixel_density_detector: bright pixel density in the frame border
// Counts bright pixels in the left, right and bottom bands of a raster frame
// and flags the frame when their share of the band area reaches a threshold.
// ----------------------------------------------------------------------------
// One pixel item is taken every clock while req_stall is low. Each item
// passes an input register (luma and brightness test), a count stage
// (position and band accumulator) and a result register (threshold
// compare), in that order. The input stalls only while a result waits in
// the output register and the next result has reached the count stage.
// Derived frame size and band area are registered from the register values;
// the threshold product is registered from the registered band area.
// ----------------------------------------------------------------------------
module border_pixel_density_detector #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int BAND_WIDTH = 5
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // pixel items
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [bpdd_pkg::PIX_W-1:0]         req_blue,
   input  wire logic [bpdd_pkg::PIX_W-1:0]         req_green,
   input  wire logic [bpdd_pkg::PIX_W-1:0]         req_red,
   input  wire logic                               req_frame_start,
   // frame results
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_hurt_detected,
   output logic      [bpdd_pkg::COUNT_W-1:0]       rsp_border_count,
   output logic      [bpdd_pkg::COUNT_W-1:0]       rsp_border_area,
   // configuration
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [bpdd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [bpdd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [bpdd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                    csr_pready
);
   import bpdd_pkg::*;

   localparam int CW       = $clog2(MAX_WIDTH);
   localparam int RW       = $clog2(MAX_HEIGHT);
   localparam int EWW      = $clog2(MAX_WIDTH + 1);
   localparam int EHW      = $clog2(MAX_HEIGHT + 1);
   localparam int AREA_MAX = 2 * BAND_WIDTH * MAX_HEIGHT + BAND_WIDTH * MAX_WIDTH;
   localparam int AW       = $clog2(AREA_MAX + 1);
   localparam int PW       = THR_W + AW;
   localparam int CMPW     = (PW > COUNT_W + 16) ? PW : COUNT_W + 16;

   csr_regs_type regs;

   bpdd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .regs        (regs)
   );

   // ---------------------------------------------------------------- derived
   logic [EWW-1:0]   ew_in, ew_ff;
   logic [EHW-1:0]   eh_in, eh_ff;
   logic [AW-1:0]    area_in, area_ff;
   logic [THR_W-1:0] thr;
   logic [PW-1:0]    prod_ff;

   // Saturate frame size to the band width and the maximum
   always_comb begin
      if (32'(regs.frame_width) < 32'(BAND_WIDTH))
         ew_in = EWW'(BAND_WIDTH);
      else if (32'(regs.frame_width) > 32'(MAX_WIDTH))
         ew_in = EWW'(MAX_WIDTH);
      else
         ew_in = EWW'(regs.frame_width);
      if (32'(regs.frame_height) < 32'(BAND_WIDTH))
         eh_in = EHW'(BAND_WIDTH);
      else if (32'(regs.frame_height) > 32'(MAX_HEIGHT))
         eh_in = EHW'(MAX_HEIGHT);
      else
         eh_in = EHW'(regs.frame_height);
      area_in = AW'(2 * BAND_WIDTH) * AW'(eh_in) + AW'(BAND_WIDTH) * AW'(ew_in);
   end

   assign thr = (regs.ratio_threshold == '0) ? THR_W'(1) : regs.ratio_threshold;

   always_ff @(posedge clock) begin
      ew_ff   <= ew_in;
      eh_ff   <= eh_in;
      area_ff <= area_in;
      prod_ff <= PW'(thr) * PW'(area_ff);
   end

   // ---------------------------------------------------------------- control
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic adv;

   // Hold the pixel stages only when a result cannot move into the output register
   assign adv       = !(s2_valid_ff && rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // ---------------------------------------------------------------- stage 1
   logic s1_bright_ff, s1_start_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else if (adv)
         s1_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_bright_ff <= luma_bright(req_blue, req_green, req_red);
         s1_start_ff  <= req_frame_start;
      end
   end

   // ---------------------------------------------------------------- count
   logic [CW-1:0]      col_ff, col;
   logic [RW-1:0]      row_ff, row;
   logic [COUNT_W-1:0] acc_ff, acc, acc_next;
   logic [COUNT_W:0]   acc_sum;
   logic [1:0]         bands;
   logic               in_left, in_right, in_bottom, last_col, last_row;

   always_comb begin
      col = s1_start_ff ? '0 : col_ff;
      row = s1_start_ff ? '0 : row_ff;
      acc = s1_start_ff ? '0 : acc_ff;
      in_left   = 32'(col) < 32'(BAND_WIDTH);
      in_right  = EWW'(col) >= ew_ff - EWW'(BAND_WIDTH);
      in_bottom = EHW'(row) >= eh_ff - EHW'(BAND_WIDTH);
      bands     = s1_bright_ff ? (2'(in_left) + 2'(in_right) + 2'(in_bottom)) : 2'd0;
      acc_sum   = (COUNT_W + 1)'(acc) + (COUNT_W + 1)'(bands);
      acc_next  = acc_sum[COUNT_W] ? '1 : acc_sum[COUNT_W-1:0];
      last_col  = EWW'(col) >= ew_ff - EWW'(1);
      last_row  = EHW'(row) >= eh_ff - EHW'(1);
   end

   // Advance position and accumulator, wrap after the last pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         acc_ff <= '0;
      end else if (adv && s1_valid_ff) begin
         if (!last_col) begin
            col_ff <= col + CW'(1);
            row_ff <= row;
            acc_ff <= acc_next;
         end else if (!last_row) begin
            col_ff <= '0;
            row_ff <= row + RW'(1);
            acc_ff <= acc_next;
         end else begin
            col_ff <= '0;
            row_ff <= '0;
            acc_ff <= '0;
         end
      end
   end

   // ---------------------------------------------------------------- stage 2
   logic [COUNT_W-1:0] s2_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s2_valid_ff <= 1'b0;
      else if (adv)
         s2_valid_ff <= s1_valid_ff && last_col && last_row;
   end

   always_ff @(posedge clock) begin
      if (adv)
         s2_cnt_ff <= acc_next;
   end

   // ---------------------------------------------------------------- result
   logic                hurt_in;
   logic [COUNT_W-1:0]  area_sat;
   logic [COUNT_W-1:0]  count_out_ff, area_out_ff;
   logic                hurt_out_ff;

   assign hurt_in  = CMPW'({s2_cnt_ff, 16'd0}) >= CMPW'(prod_ff);
   assign area_sat = (32'(area_ff) > 32'(16'hFFFF)) ? '1 : COUNT_W'(area_ff);

   // Load a result, drop it once taken
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (adv && s2_valid_ff)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff) begin
         hurt_out_ff  <= hurt_in;
         count_out_ff <= s2_cnt_ff;
         area_out_ff  <= area_sat;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hurt_detected = hurt_out_ff;
   assign rsp_border_count  = count_out_ff;
   assign rsp_border_area   = area_out_ff;

endmodule
`default_nettype wire
